>>> design/oaht_pkg.sv
// Shared types and codes for the open-addressing hash table.
// Slot entry layout, result layout, state machine encodings, request and status codes.
// No dependencies.
package oaht_pkg;

  localparam int KEY_W  = 64;
  localparam int VAL_W  = 16;
  // Widest (h + c) * c for up to 1024 slots: (1023 + 255) * 255 < 2**19
  localparam int PROD_W = 19;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       slot;
    logic [VAL_W-1:0] value;
  } result_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MUL,
    HS_QUO,
    HS_RED
  } hash_state_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HSTART,
    CS_HASH,
    CS_READ,
    CS_PROBE,
    CS_DONE
  } ctrl_state_t;

endpackage

>>> design/oaht_hash.sv
// Serial key hash: h = ((h + c) * c) mod TABLE_SLOTS, one character at a time through the
// multiply, quotient and reduce states. The modulo uses a reciprocal multiply with one correction step.
// Depends on oaht_pkg.
module oaht_hash #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [oaht_pkg::KEY_W-1:0]     key,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] h
);
  import oaht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam logic [PROD_W-1:0] MOD_M   = PROD_W'((64'd1 << PROD_W) / TABLE_SLOTS);
  localparam logic [PROD_W-1:0] SLOTS_X = PROD_W'(TABLE_SLOTS);

  hash_state_t state_r, state_nxt;
  logic [3:0]        idx_r;
  logic [SW-1:0]     h_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] q_r;
  logic [7:0]        ch;
  logic              key_end;
  logic [2*PROD_W-1:0] qfull;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] rem_c;

  assign ch      = key[idx_r[2:0]*8 +: 8];
  assign key_end = idx_r[3] || (ch == 8'd0);
  assign qfull   = {{PROD_W{1'b0}}, prod_r} * {{PROD_W{1'b0}}, MOD_M};
  assign rem     = prod_r - q_r * SLOTS_X;
  assign rem_c   = (rem >= SLOTS_X) ? (rem - SLOTS_X) : rem;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      HS_IDLE: if (start) state_nxt = HS_MUL;
      HS_MUL:  state_nxt = key_end ? HS_IDLE : HS_QUO;
      HS_QUO:  state_nxt = HS_RED;
      HS_RED:  state_nxt = HS_MUL;
      default: state_nxt = HS_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == HS_MUL) && key_end;
    h    = h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      HS_IDLE: begin
        if (start) begin
          idx_r <= 4'd0;
          h_r   <= '0;
        end
      end
      HS_MUL: prod_r <= (PROD_W'(h_r) + PROD_W'(ch)) * PROD_W'(ch);
      HS_QUO: q_r <= qfull[2*PROD_W-1:PROD_W];
      HS_RED: begin
        h_r   <= SW'(rem_c);
        idx_r <= idx_r + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

>>> design/oaht_ctrl.sv
// Probe engine: slot memory, clearing pass after reset, linear probe with
// read-ahead, insert/lookup/delete write-back and the result holding register.
// Depends on oaht_pkg.
module oaht_ctrl #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     req_op,
  input  logic [oaht_pkg::KEY_W-1:0]     req_key,
  input  logic [oaht_pkg::VAL_W-1:0]     req_value,
  output logic                           hash_start,
  output logic [oaht_pkg::KEY_W-1:0]     hash_key,
  input  logic                           hash_done,
  input  logic [$clog2(TABLE_SLOTS)-1:0] hash_h,
  output logic                           res_valid,
  input  logic                           res_ready,
  output oaht_pkg::result_t              res
);
  import oaht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam logic [SW-1:0] LAST = SW'(TABLE_SLOTS - 1);

  entry_t mem [TABLE_SLOTS];
  entry_t rdata_r;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [SW-1:0]    cur_r;
  logic [SW-1:0]    cnt_r;
  logic [SW-1:0]    clr_r;
  result_t          res_r;

  logic [SW-1:0] cur_next;
  logic [SW-1:0] raddr;
  logic [SW-1:0] waddr;
  logic          we;
  entry_t        wdata;
  logic          stop;
  logic          res_load;
  result_t       res_nxt;
  logic          op_ok;

  assign cur_next = (cur_r == LAST) ? '0 : cur_r + 1'b1;
  assign op_ok    = (op_r == OP_INSERT) || (op_r == OP_LOOKUP) || (op_r == OP_DELETE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_CLEAR:  if (clr_r == LAST) state_nxt = CS_IDLE;
      CS_IDLE:   if (req_valid) state_nxt = CS_HSTART;
      CS_HSTART: state_nxt = CS_HASH;
      CS_HASH:   if (hash_done) state_nxt = op_ok ? CS_READ : CS_DONE;
      CS_READ:   state_nxt = CS_PROBE;
      CS_PROBE:  if (stop) state_nxt = CS_DONE;
      CS_DONE:   if (res_ready) state_nxt = CS_IDLE;
      default:   state_nxt = CS_CLEAR;
    endcase
  end

  always_comb begin
    req_ready  = (state_r == CS_IDLE);
    hash_start = (state_r == CS_HSTART);
    hash_key   = key_r;
    res_valid  = (state_r == CS_DONE);
    res        = res_r;
    raddr      = cur_next;
    we         = 1'b0;
    waddr      = cur_r;
    wdata      = '{mark: MARK_USED, key: key_r, value: val_r};
    stop       = 1'b0;
    res_load   = 1'b0;
    res_nxt    = '{status: STAT_NOT_FOUND, slot: 4'd0, value: '0};
    unique case (state_r)
      CS_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '{mark: MARK_EMPTY, key: '0, value: '0};
      end
      CS_HASH: begin
        res_load = hash_done && !op_ok;
      end
      CS_READ: begin
        raddr = hash_h;
      end
      CS_PROBE: begin
        if (op_r == OP_INSERT) begin
          if (rdata_r.mark != MARK_USED) begin
            stop    = 1'b1;
            we      = 1'b1;
            res_nxt = '{status: STAT_DONE, slot: 4'(cur_r), value: '0};
          end else if (cnt_r == LAST) begin
            stop    = 1'b1;
            res_nxt = '{status: STAT_FULL, slot: 4'd0, value: '0};
          end
        end else begin
          if (rdata_r.mark == MARK_EMPTY) begin
            stop = 1'b1;
          end else if (rdata_r.mark == MARK_USED && rdata_r.key == key_r) begin
            stop    = 1'b1;
            we      = (op_r == OP_DELETE);
            wdata   = '{mark: MARK_DELETED, key: rdata_r.key, value: rdata_r.value};
            res_nxt = '{status: STAT_DONE, slot: 4'(cur_r), value: rdata_r.value};
          end else if (cnt_r == LAST) begin
            stop = 1'b1;
          end
        end
        res_load = stop;
      end
      default: ;
    endcase
  end

  // Slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == CS_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == CS_IDLE && req_valid) begin
      op_r  <= req_op;
      key_r <= req_key;
      val_r <= req_value;
    end
    if (state_r == CS_READ) begin
      cur_r <= hash_h;
      cnt_r <= '0;
    end else if (state_r == CS_PROBE && !stop) begin
      cur_r <= cur_next;
      cnt_r <= cnt_r + 1'b1;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> design/open_addressing_hash_table_core.sv
// Flow: each request is hashed, then probed from the hashed slot (1..TABLE_SLOTS slots);
//   opcode 3 skips read and probe.
// Requests: one at a time; a new request is accepted only after the result has been
//   passed to the output register.
// Reset: synchronous, active low; then a clearing pass marks every slot
//   empty, with in_tready low.
module open_addressing_hash_table_core #(
  parameter int TABLE_SLOTS = 16,
  parameter int KEY_CHARS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // key[63:0], value[79:64]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // slot[3:0], found_value[19:4], zero[23:20]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import oaht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);

  logic [KEY_W-1:0] nkey;
  logic             alive;
  logic             hash_start;
  logic [KEY_W-1:0] hash_key;
  logic             hash_done;
  logic [SW-1:0]    hash_h;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_r;
  result_t          out_res_r;

  // Cut the key at its first zero byte and at KEY_CHARS characters
  always_comb begin
    alive = 1'b1;
    nkey  = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_CHARS || in_tdata[8*i +: 8] == 8'd0) alive = 1'b0;
      if (alive) nkey[8*i +: 8] = in_tdata[8*i +: 8];
    end
  end

  oaht_hash #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hash_start),
    .key  (hash_key),
    .done (hash_done),
    .h    (hash_h)
  );

  oaht_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tuser),
    .req_key   (nkey),
    .req_value (in_tdata[79:64]),
    .hash_start(hash_start),
    .hash_key  (hash_key),
    .hash_done (hash_done),
    .hash_h    (hash_h),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.value, out_res_r.slot};
  assign out_tuser  = out_res_r.status;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for open_addressing_hash_table_core: stream driver, result
// monitor and a shadow copy of the slot store that predicts each response.
// Depends on oaht_pkg (codes, result layout) and the core itself.
module testbench;
  import oaht_pkg::*;

  localparam int SLOTS      = 16;
  localparam int CHARS      = 8;
  localparam int POOL_N     = 24;
  localparam int RAND_REQS  = 900;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYC   = 80;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [15:0] value;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  open_addressing_hash_table_core #(
    .TABLE_SLOTS(SLOTS),
    .KEY_CHARS  (CHARS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  req_t        pending_reqs[$];
  result_t     expected_results[$];
  logic [1:0]  shadow_mark[SLOTS];
  logic [63:0] shadow_key[SLOTS];
  logic [15:0] shadow_value[SLOTS];
  logic [63:0] key_pool[POOL_N];
  int          key_len[POOL_N];
  int          n_errors = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          burst_left = 1;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  pattern_pos = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow table: computes the response for one request and updates the slot store.
  task automatic hash_table_predict(input req_t r);
    logic [63:0] nkey;
    logic [7:0]  c;
    int unsigned h, s, i;
    bit          stop;
    result_t     res;
    nkey = '0;
    stop = 1'b0;
    for (i = 0; i < CHARS; i++) begin
      if (r.key[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) nkey[8*i +: 8] = r.key[8*i +: 8];
    end
    h = 0;
    stop = 1'b0;
    for (i = 0; i < 8; i++) begin
      c = nkey[8*i +: 8];
      if (c == 8'd0) stop = 1'b1;
      if (!stop) h = ((h + c) * c) % SLOTS;
    end
    res.status = STAT_NOT_FOUND;
    res.slot   = '0;
    res.value  = '0;
    stop = 1'b0;
    case (r.op)
      OP_INSERT: begin
        res.status = STAT_FULL;
        for (i = 0; i < SLOTS; i++) begin
          s = (h + i) % SLOTS;
          if (!stop && shadow_mark[s] != MARK_USED) begin
            shadow_mark[s]  = MARK_USED;
            shadow_key[s]   = nkey;
            shadow_value[s] = r.value;
            res.status = STAT_DONE;
            res.slot   = s[3:0];
            stop = 1'b1;
          end
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        for (i = 0; i < SLOTS; i++) begin
          s = (h + i) % SLOTS;
          if (!stop) begin
            if (shadow_mark[s] == MARK_EMPTY) begin
              stop = 1'b1;
            end else if (shadow_mark[s] == MARK_USED && shadow_key[s] == nkey) begin
              res.status = STAT_DONE;
              res.slot   = s[3:0];
              res.value  = shadow_value[s];
              if (r.op == OP_DELETE) shadow_mark[s] = MARK_DELETED;
              stop = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endtask

  function automatic logic [63:0] random_key(input int len);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Junk after the terminator must be ignored by hash, compare and store.
  function automatic logic [63:0] add_tail_junk(input logic [63:0] k, input int len);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if (len < 7 && $urandom_range(0, 2) == 0) return k | (junk << (8 * (len + 1)));
    return k;
  endfunction

  task automatic queue_req(input logic [1:0] op, input logic [63:0] key,
                           input logic [15:0] value);
    req_t r;
    r.op    = op;
    r.key   = key;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // Driver: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      for (int i = 0; i < SLOTS; i++) shadow_mark[i] = MARK_EMPTY;
    end else begin
      if (in_tvalid && in_tready) begin
        hash_table_predict({in_tuser, in_tdata[63:0], in_tdata[79:64]});
        void'(pending_reqs.pop_front());
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
        end
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pending_reqs[0].value, pending_reqs[0].key};
          in_tuser  <= pending_reqs[0].op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: a fresh 16-bit ready pattern each time the 6-bit position wraps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      pattern_pos <= '0;
    end else begin
      if (pattern_pos == 6'd0) begin
        if ($urandom_range(0, 2) == 0) ready_pattern = 16'hFFFF;
        else ready_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      end
      pattern_pos <= pattern_pos + 6'd1;
      out_tready  <= ready_pattern[pattern_pos[3:0]];
    end
  end

  // Monitor: each response against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected response status=%0d slot=%0d value=%h",
                   out_tuser, out_tdata[3:0], out_tdata[19:4]);
      end else begin
        if (out_tuser != expected_results[0].status ||
            out_tdata[3:0] != expected_results[0].slot ||
            out_tdata[19:4] != expected_results[0].value) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"ERROR: response mismatch exp status=%0d slot=%0d value=%h,",
                      " got status=%0d slot=%0d value=%h"},
                     expected_results[0].status, expected_results[0].slot,
                     expected_results[0].value, out_tuser, out_tdata[3:0],
                     out_tdata[19:4]);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // Watchdog on handshake inactivity.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int          sel, pick, ins_weight;
    logic [1:0]  op;
    logic [63:0] key;
    for (int i = 0; i < POOL_N; i++) begin
      key_len[i]  = (i % 3 == 0) ? 8 : $urandom_range(1, 8);
      key_pool[i] = random_key(key_len[i]);
    end
    key_len[POOL_N-1]  = 0;
    key_pool[POOL_N-1] = '0;

    // Directed: empty-table miss, empty key, unused opcode, all-ones key,
    // terminator in mid-key, delete twice, fill to full, exhausted probe.
    queue_req(OP_LOOKUP, 64'h41, 16'h1234);
    queue_req(OP_INSERT, 64'h0, 16'hFFFF);
    queue_req(OP_LOOKUP, 64'h0, 16'h0);
    queue_req(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    queue_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    queue_req(OP_INSERT, 64'h00FF_5A59_5800_4241, 16'hA5A5);
    queue_req(OP_LOOKUP, 64'h4241, 16'h0);
    queue_req(OP_DELETE, 64'h4241, 16'h0);
    queue_req(OP_DELETE, 64'h4241, 16'h0);
    for (int i = 0; i < 14; i++) queue_req(OP_INSERT, key_pool[i], 16'($urandom));
    queue_req(OP_INSERT, key_pool[14], 16'h5A5A);
    queue_req(OP_DELETE, key_pool[0], 16'h0);
    queue_req(OP_LOOKUP, key_pool[15], 16'h0);

    // Random: pool keys so that hits are common; insert-heavy and delete-heavy phases.
    for (int n = 0; n < RAND_REQS; n++) begin
      ins_weight = ((n / 150) % 2 == 0) ? 55 : 25;
      sel  = $urandom_range(0, 99);
      pick = $urandom_range(0, POOL_N - 1);
      key  = add_tail_junk(key_pool[pick], key_len[pick]);
      if (sel < 5) begin
        op  = 2'($urandom_range(0, 3));
        key = {$urandom, $urandom};
      end else if (sel < 5 + ins_weight) begin
        op = OP_INSERT;
      end else if (sel < 5 + ins_weight + (95 - ins_weight) / 2) begin
        op = OP_LOOKUP;
      end else begin
        op = OP_DELETE;
      end
      queue_req(op, key, 16'($urandom));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
